>>> design/rp32_pkg.sv
`default_nettype none

package rp32_pkg;

    // Slot count and generator constants
    localparam int NUM_SLOTS_DEF = 32;
    localparam int SEED_W        = 32;
    localparam int VALUE_W       = 32;
    localparam int CAND_W        = 6;
    localparam int CAND_LSB      = 2;

    localparam logic [SEED_W-1:0]  LCG_MUL     = 32'h0019_660D;
    localparam logic [SEED_W-1:0]  LCG_ADD     = 32'h3C6E_F35F;
    localparam logic [VALUE_W-1:0] RESEED_WORD = 32'h610A_660F;

    // Request kinds
    localparam logic KIND_RESEED = 1'b0;
    localparam logic KIND_DRAW   = 1'b1;

    // Control from the sequencer to the slot map
    typedef struct packed {
        logic clear;
        logic mark;
    } map_ctrl_t;

    // Status from the slot map to the sequencer
    typedef struct packed {
        logic cand_free;
        logic all_used;
    } map_stat_t;

endpackage

`default_nettype wire

>>> design/rp32_lcg.sv
`default_nettype none

module rp32_lcg
(
    input  wire logic [rp32_pkg::SEED_W-1:0] x,
    output logic      [rp32_pkg::SEED_W-1:0] y
);

    // One generator step, product truncated to the seed width
    assign y = x * rp32_pkg::LCG_MUL + rp32_pkg::LCG_ADD;

endmodule

`default_nettype wire

>>> design/rp32_slot_map.sv
`default_nettype none

module rp32_slot_map
#(
    parameter int NUM_SLOTS = rp32_pkg::NUM_SLOTS_DEF,
    parameter int SLOT_W    = $clog2(NUM_SLOTS)
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire rp32_pkg::map_ctrl_t         ctrl,
    input  wire logic [rp32_pkg::CAND_W-1:0] cand_bits,
    output logic      [SLOT_W-1:0]           cand_slot,
    output rp32_pkg::map_stat_t              stat
);

    localparam int CandCount = 2 ** rp32_pkg::CAND_W;

    logic [NUM_SLOTS-1:0] marks_reg;
    logic [NUM_SLOTS-1:0] marks_next;
    logic [SLOT_W-1:0]    cand_lut [CandCount];

    // Candidate bits modulo the slot count, fixed at elaboration
    for (genvar i = 0; i < CandCount; i++) begin : g_lut
        assign cand_lut[i] = SLOT_W'(i % NUM_SLOTS);
    end

    assign cand_slot      = cand_lut[cand_bits];
    assign stat.cand_free = !marks_reg[cand_slot];
    assign stat.all_used  = &marks_reg;

    // Used marks: clear on reseed, set on a successful draw
    always_comb
    begin
        marks_next = marks_reg;
        if (ctrl.clear)
        begin
            marks_next = '0;
        end
        else if (ctrl.mark)
        begin
            marks_next[cand_slot] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marks_reg <= '0;
        end
        else
        begin
            marks_reg <= marks_next;
        end
    end

endmodule

`default_nettype wire

>>> design/random_permutation_of_32.sv
`default_nettype none

// Hands out slot numbers 0..NUM_SLOTS-1 in pseudo-random order, each at most
// once between reseeds. A reseed request (kind 0) clears all marks, loads
// seed_value when it is nonzero and answers 0x610A660F; the answer passes
// through the result registers and the emit state into the output register.
// A draw request (kind 1) steps the 32-bit linear congruential generator
// once per cycle until bits 7..2 of the seed, modulo NUM_SLOTS, name an
// unused slot, using the single shared multiply-add unit for every step;
// the slot then takes the same path to the output register. While out_stall
// holds a valid output, the result waits in the emit state.
// A draw with every slot used answers value 0 with exhausted set and leaves
// the state as it was; it is timed like a reseed. One request is in flight
// at a time; in_stall is high from accept until the result has been moved
// into the output register.
module random_permutation_of_32
#(
    parameter int NUM_SLOTS = rp32_pkg::NUM_SLOTS_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          kind,
    input  wire logic [rp32_pkg::SEED_W-1:0]   seed_value,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [rp32_pkg::VALUE_W-1:0]  value,
    output logic                               exhausted
);

    localparam int SLOT_W = $clog2(NUM_SLOTS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_EMIT
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    logic [rp32_pkg::SEED_W-1:0]     seed_reg;
    logic [rp32_pkg::SEED_W-1:0]     seed_next;
    logic [rp32_pkg::VALUE_W-1:0]    res_value_reg;
    logic [rp32_pkg::VALUE_W-1:0]    res_value_next;
    logic                            res_exh_reg;
    logic                            res_exh_next;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [rp32_pkg::VALUE_W-1:0]    value_reg;
    logic [rp32_pkg::VALUE_W-1:0]    value_next;
    logic                            exhausted_reg;
    logic                            exhausted_next;

    logic [rp32_pkg::SEED_W-1:0]     lcg_y;
    logic [SLOT_W-1:0]               cand_slot;
    rp32_pkg::map_ctrl_t             map_ctrl;
    rp32_pkg::map_stat_t             map_stat;
    logic                            out_free;

    // Shared generator step
    rp32_lcg u_lcg
    (
        .x (seed_reg),
        .y (lcg_y)
    );

    // Used-slot map and candidate decode
    rp32_slot_map
    #(
        .NUM_SLOTS (NUM_SLOTS),
        .SLOT_W    (SLOT_W)
    )
    u_map
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (map_ctrl),
        .cand_bits (seed_reg[rp32_pkg::CAND_LSB +: rp32_pkg::CAND_W]),
        .cand_slot (cand_slot),
        .stat      (map_stat)
    );

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign exhausted = exhausted_reg;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        seed_next      = seed_reg;
        res_value_next = res_value_reg;
        res_exh_next   = res_exh_reg;
        out_valid_next = out_valid_reg;
        value_next     = value_reg;
        exhausted_next = exhausted_reg;
        map_ctrl       = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (kind == rp32_pkg::KIND_RESEED)
                    begin
                        map_ctrl.clear = 1'b1;
                        if (seed_value != '0)
                        begin
                            seed_next = seed_value;
                        end
                        res_value_next = rp32_pkg::RESEED_WORD;
                        res_exh_next   = 1'b0;
                        state_next     = ST_EMIT;
                    end
                    else if (map_stat.all_used)
                    begin
                        res_value_next = '0;
                        res_exh_next   = 1'b1;
                        state_next     = ST_EMIT;
                    end
                    else
                    begin
                        seed_next  = lcg_y;
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                // candidate of the current seed: take it or step again
                if (map_stat.cand_free)
                begin
                    map_ctrl.mark  = 1'b1;
                    res_value_next = rp32_pkg::VALUE_W'(cand_slot);
                    res_exh_next   = 1'b0;
                    state_next     = ST_EMIT;
                end
                else
                begin
                    seed_next = lcg_y;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    value_next     = res_value_reg;
                    exhausted_next = res_exh_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seed_reg      <= '0;
            res_value_reg <= '0;
            res_exh_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            value_reg     <= '0;
            exhausted_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seed_reg      <= seed_next;
            res_value_reg <= res_value_next;
            res_exh_reg   <= res_exh_next;
            out_valid_reg <= out_valid_next;
            value_reg     <= value_next;
            exhausted_reg <= exhausted_next;
        end
    end

    // Checks
    a_exh_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && exhausted |-> value == '0)
        else $error("exhausted result carries a nonzero value");

    a_search_has_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SEARCH |-> !map_stat.all_used)
        else $error("search running with every slot used");

    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !exhausted && value != rp32_pkg::RESEED_WORD
            |-> value < rp32_pkg::VALUE_W'(NUM_SLOTS))
        else $error("drawn slot out of range");

endmodule

`default_nettype wire
